@@ sv/gcm_pkg.sv @@
`timescale 1ns / 1ps

package gcm_pkg;

  localparam int MOD_WIDTH_DEF = 32;
  localparam int DATA_W        = 64;   // shared unit operand width
  localparam int MUL_B_W       = 32;   // multiplier operand width
  localparam int PROD_W        = DATA_W + MUL_B_W;
  localparam int ACC_W         = 63;
  localparam int DIV_STEPS     = DATA_W;
  localparam int MUL_STEPS     = MUL_B_W;
  localparam int CNT_W         = 7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOSOL = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  typedef enum logic {
    OP_DIV,
    OP_MUL
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_FIRST,
    S_R2,
    S_GCD,
    S_GCD_STEP,
    S_R1G,
    S_R2G,
    S_Q,
    S_OVF,
    S_M2G,
    S_R1M,
    S_DQ,
    S_A,
    S_EU,
    S_EU_DIV,
    S_EU_MUL,
    S_INV,
    S_T,
    S_TM,
    S_MT,
    S_RES,
    S_DONE
  } state_t;

endpackage

@@ sv/gcm_alu.sv @@
`timescale 1ns / 1ps

// Shared unit: restoring divider (quotient and remainder) and shift-add multiplier.
module gcm_alu (
  input  logic                          clk,
  input  logic                          rst,
  input  gcm_pkg::alu_req_t             req,
  input  logic [gcm_pkg::DATA_W-1:0]    a,
  input  logic [gcm_pkg::DATA_W-1:0]    b,
  output logic                          done,
  output logic [gcm_pkg::DATA_W-1:0]    quo,
  output logic [gcm_pkg::DATA_W-1:0]    rem,
  output logic [gcm_pkg::PROD_W-1:0]    prod
);

  logic                             busy;
  gcm_pkg::alu_op_t                 op;
  logic [gcm_pkg::CNT_W-1:0]        cnt;
  logic [gcm_pkg::DATA_W-1:0]       den;
  logic [gcm_pkg::MUL_B_W-1:0]      mplier;
  logic [gcm_pkg::DATA_W:0]         trial;
  logic [gcm_pkg::DATA_W:0]         psum;

  assign trial = {rem, quo[gcm_pkg::DATA_W-1]};
  assign psum  = {1'b0, prod[gcm_pkg::PROD_W-1:gcm_pkg::MUL_B_W]}
               + (mplier[0] ? {1'b0, den} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op   <= gcm_pkg::OP_DIV;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        cnt  <= (req.op == gcm_pkg::OP_DIV) ? gcm_pkg::CNT_W'(gcm_pkg::DIV_STEPS)
                                            : gcm_pkg::CNT_W'(gcm_pkg::MUL_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == gcm_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      if (req.op == gcm_pkg::OP_DIV) begin
        den <= b;
        quo <= a;
        rem <= '0;
      end else begin
        den    <= a;
        mplier <= b[gcm_pkg::MUL_B_W-1:0];
        prod   <= '0;
      end
    end else if (busy) begin
      if (op == gcm_pkg::OP_DIV) begin
        if (trial >= {1'b0, den}) begin
          rem <= gcm_pkg::DATA_W'(trial - {1'b0, den});
          quo <= {quo[gcm_pkg::DATA_W-2:0], 1'b1};
        end else begin
          rem <= trial[gcm_pkg::DATA_W-1:0];
          quo <= {quo[gcm_pkg::DATA_W-2:0], 1'b0};
        end
      end else begin
        prod   <= {psum, prod[gcm_pkg::MUL_B_W-1:1]};
        mplier <= mplier >> 1;
      end
    end
  end

endmodule

@@ sv/general_crt_merge.sv @@
`timescale 1ns / 1ps

// general_crt_merge: merges congruences x = residue (mod modulus), moduli not
// necessarily coprime, into one running congruence.
// Input channel s_*: one item per congruence; s_tuser = first starts a new
// system. Output channel m_*: one item per input item giving the merged
// residue, lcm modulus and status (0 ok, 1 no solution, 2 lcm beyond 63 bits).
// A failure is sticky until the next first item; while failed the item just
// reports the failure.
// One item at a time: each item runs a sequence of divisions and
// multiplications on one shared unit. A first item runs one division, an item
// ignored under a failure none; a merge adds one division per Euclid step of the
// gcd and a division and a multiplication per step of the modular inverse,
// which is skipped when m2/g is 1.
// The sequencer over the shared unit sets the order of these operations.
// The result sits in an output register; the next item is taken while it waits,
// and only a second result stalls behind an unread one.
// Reset: the merged system becomes x = 0 (mod 1), status ok, output empty.
module general_crt_merge #(
  parameter int MOD_WIDTH = gcm_pkg::MOD_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // residue [31:0], modulus [63:32]
  input  logic         s_tuser,   // first
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // merged_residue [62:0], merged_modulus [125:63], status [127:126]
);

  localparam int W  = MOD_WIDTH;
  localparam int CW = MOD_WIDTH + 2;
  localparam int DW = gcm_pkg::DATA_W;

  gcm_pkg::state_t state, state_next, ret, ret_next;
  gcm_pkg::alu_req_t req;
  logic [DW-1:0] alu_a, alu_b, quo, rem;
  logic [gcm_pkg::PROD_W-1:0] prod;
  logic alu_done;

  logic fail_en;
  logic [1:0] fail_code;

  // item and merge registers
  logic [W-1:0] rin, min, r2, g, tmp, m2g, d, t, e_r0, e_r1;
  logic first_in;
  logic [DW-1:0] ga;
  logic [gcm_pkg::ACC_W-1:0] q, lcm;
  logic signed [CW-1:0] c0, c1, c1_abs, pe, ct, inv_s;
  logic [W:0] dsum;
  logic [W-1:0] dd, inv_val;

  logic [gcm_pkg::ACC_W-1:0] acc_res, acc_mod;
  logic [1:0] acc_st;
  logic [gcm_pkg::ACC_W-1:0] out_res, out_mod;
  logic [1:0] out_st;

  gcm_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .a    (alu_a),
    .b    (alu_b),
    .done (alu_done),
    .quo  (quo),
    .rem  (rem),
    .prod (prod)
  );

  assign s_tready = (state == gcm_pkg::S_IDLE);
  assign m_tdata  = {out_st, out_mod, out_res};

  // difference of residues, brought into [0, m2); r1 mod m2 is fresh in rem
  assign dsum = {1'b0, r2} + {1'b0, min} - {1'b0, rem[W-1:0]};
  assign dd   = (r2 >= rem[W-1:0]) ? (r2 - rem[W-1:0]) : dsum[W-1:0];

  // extended Euclid coefficient update
  assign c1_abs  = c1[CW-1] ? -c1 : c1;
  assign pe      = signed'(prod[CW-1:0]);
  assign ct      = c0 - (c1[CW-1] ? -pe : pe);
  assign inv_s   = c0[CW-1] ? (c0 + signed'({2'b00, m2g})) : c0;
  assign inv_val = inv_s[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcm_pkg::S_IDLE;
      ret   <= gcm_pkg::S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    req.start  = 1'b0;
    req.op     = gcm_pkg::OP_DIV;
    alu_a      = '0;
    alu_b      = '0;
    fail_en    = 1'b0;
    fail_code  = gcm_pkg::ST_NOSOL;
    unique case (state)
      gcm_pkg::S_IDLE: begin
        if (s_tvalid) state_next = gcm_pkg::S_START;
      end
      gcm_pkg::S_START: begin
        if (first_in) begin
          if (min == '0) begin
            fail_en    = 1'b1;
            state_next = gcm_pkg::S_DONE;
          end else begin
            req.start  = 1'b1;
            alu_a      = DW'(rin);
            alu_b      = DW'(min);
            ret_next   = gcm_pkg::S_FIRST;
            state_next = gcm_pkg::S_WAIT;
          end
        end else if (acc_st != gcm_pkg::ST_OK) begin
          state_next = gcm_pkg::S_DONE;
        end else if (min == '0 || acc_mod == '0) begin
          fail_en    = 1'b1;
          state_next = gcm_pkg::S_DONE;
        end else begin
          req.start  = 1'b1;
          alu_a      = DW'(rin);
          alu_b      = DW'(min);
          ret_next   = gcm_pkg::S_R2;
          state_next = gcm_pkg::S_WAIT;
        end
      end
      gcm_pkg::S_WAIT: begin
        if (alu_done) state_next = ret;
      end
      gcm_pkg::S_FIRST: state_next = gcm_pkg::S_DONE;
      gcm_pkg::S_R2:    state_next = gcm_pkg::S_GCD;
      gcm_pkg::S_GCD: begin
        req.start  = 1'b1;
        state_next = gcm_pkg::S_WAIT;
        if (e_r1 == '0) begin
          // gcd found in ga: reduce r1 by it
          alu_a    = DW'(acc_res);
          alu_b    = ga;
          ret_next = gcm_pkg::S_R1G;
        end else begin
          alu_a    = ga;
          alu_b    = DW'(e_r1);
          ret_next = gcm_pkg::S_GCD_STEP;
        end
      end
      gcm_pkg::S_GCD_STEP: state_next = gcm_pkg::S_GCD;
      gcm_pkg::S_R1G: begin
        req.start  = 1'b1;
        alu_a      = DW'(r2);
        alu_b      = DW'(g);
        ret_next   = gcm_pkg::S_R2G;
        state_next = gcm_pkg::S_WAIT;
      end
      gcm_pkg::S_R2G: begin
        if (rem[W-1:0] != tmp) begin
          fail_en    = 1'b1;
          state_next = gcm_pkg::S_DONE;
        end else begin
          req.start  = 1'b1;
          alu_a      = DW'(acc_mod);
          alu_b      = DW'(g);
          ret_next   = gcm_pkg::S_Q;
          state_next = gcm_pkg::S_WAIT;
        end
      end
      gcm_pkg::S_Q: begin
        req.start  = 1'b1;
        req.op     = gcm_pkg::OP_MUL;
        alu_a      = quo;
        alu_b      = DW'(min);
        ret_next   = gcm_pkg::S_OVF;
        state_next = gcm_pkg::S_WAIT;
      end
      gcm_pkg::S_OVF: begin
        if (prod[gcm_pkg::PROD_W-1:gcm_pkg::ACC_W] != '0) begin
          fail_en    = 1'b1;
          fail_code  = gcm_pkg::ST_OVF;
          state_next = gcm_pkg::S_DONE;
        end else begin
          req.start  = 1'b1;
          alu_a      = DW'(min);
          alu_b      = DW'(g);
          ret_next   = gcm_pkg::S_M2G;
          state_next = gcm_pkg::S_WAIT;
        end
      end
      gcm_pkg::S_M2G: begin
        if (quo == DW'(1)) begin
          state_next = gcm_pkg::S_MT;
        end else begin
          req.start  = 1'b1;
          alu_a      = DW'(acc_res);
          alu_b      = DW'(min);
          ret_next   = gcm_pkg::S_R1M;
          state_next = gcm_pkg::S_WAIT;
        end
      end
      gcm_pkg::S_R1M: begin
        req.start  = 1'b1;
        alu_a      = DW'(dd);
        alu_b      = DW'(g);
        ret_next   = gcm_pkg::S_DQ;
        state_next = gcm_pkg::S_WAIT;
      end
      gcm_pkg::S_DQ: begin
        req.start  = 1'b1;
        alu_a      = DW'(q);
        alu_b      = DW'(m2g);
        ret_next   = gcm_pkg::S_A;
        state_next = gcm_pkg::S_WAIT;
      end
      gcm_pkg::S_A: state_next = gcm_pkg::S_EU;
      gcm_pkg::S_EU: begin
        if (e_r1 == '0) begin
          state_next = gcm_pkg::S_INV;
        end else begin
          req.start  = 1'b1;
          alu_a      = DW'(e_r0);
          alu_b      = DW'(e_r1);
          ret_next   = gcm_pkg::S_EU_DIV;
          state_next = gcm_pkg::S_WAIT;
        end
      end
      gcm_pkg::S_EU_DIV: begin
        req.start  = 1'b1;
        req.op     = gcm_pkg::OP_MUL;
        alu_a      = quo;
        alu_b      = DW'(c1_abs[W-1:0]);
        ret_next   = gcm_pkg::S_EU_MUL;
        state_next = gcm_pkg::S_WAIT;
      end
      gcm_pkg::S_EU_MUL: state_next = gcm_pkg::S_EU;
      gcm_pkg::S_INV: begin
        req.start  = 1'b1;
        req.op     = gcm_pkg::OP_MUL;
        alu_a      = DW'(d);
        alu_b      = DW'(inv_val);
        ret_next   = gcm_pkg::S_T;
        state_next = gcm_pkg::S_WAIT;
      end
      gcm_pkg::S_T: begin
        req.start  = 1'b1;
        alu_a      = prod[DW-1:0];
        alu_b      = DW'(m2g);
        ret_next   = gcm_pkg::S_TM;
        state_next = gcm_pkg::S_WAIT;
      end
      gcm_pkg::S_TM: state_next = gcm_pkg::S_MT;
      gcm_pkg::S_MT: begin
        req.start  = 1'b1;
        req.op     = gcm_pkg::OP_MUL;
        alu_a      = DW'(acc_mod);
        alu_b      = DW'(t);
        ret_next   = gcm_pkg::S_RES;
        state_next = gcm_pkg::S_WAIT;
      end
      gcm_pkg::S_RES: state_next = gcm_pkg::S_DONE;
      gcm_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) state_next = gcm_pkg::S_IDLE;
      end
      default: state_next = gcm_pkg::S_IDLE;
    endcase
  end

  // merged system state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_res <= '0;
      acc_mod <= gcm_pkg::ACC_W'(1);
      acc_st  <= gcm_pkg::ST_OK;
    end else if (fail_en) begin
      acc_res <= '0;
      acc_mod <= '0;
      acc_st  <= fail_code;
    end else if (state == gcm_pkg::S_FIRST) begin
      acc_res <= gcm_pkg::ACC_W'(rem[W-1:0]);
      acc_mod <= gcm_pkg::ACC_W'(min);
      acc_st  <= gcm_pkg::ST_OK;
    end else if (state == gcm_pkg::S_RES) begin
      acc_res <= acc_res + prod[gcm_pkg::ACC_W-1:0];
      acc_mod <= lcm;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      gcm_pkg::S_IDLE: begin
        rin      <= s_tdata[W-1:0];
        min      <= s_tdata[32+W-1:32];
        first_in <= s_tuser;
      end
      gcm_pkg::S_R2: begin
        r2   <= rem[W-1:0];
        ga   <= DW'(acc_mod);
        e_r1 <= min;
      end
      gcm_pkg::S_GCD: begin
        if (e_r1 == '0) g <= ga[W-1:0];
      end
      gcm_pkg::S_GCD_STEP: begin
        ga   <= DW'(e_r1);
        e_r1 <= rem[W-1:0];
      end
      gcm_pkg::S_R1G: tmp <= rem[W-1:0];
      gcm_pkg::S_Q:   q   <= quo[gcm_pkg::ACC_W-1:0];
      gcm_pkg::S_OVF: lcm <= prod[gcm_pkg::ACC_W-1:0];
      gcm_pkg::S_M2G: begin
        m2g <= quo[W-1:0];
        t   <= '0;
      end
      gcm_pkg::S_DQ:  d   <= quo[W-1:0];
      gcm_pkg::S_A: begin
        e_r0 <= m2g;
        e_r1 <= rem[W-1:0];
        c0   <= '0;
        c1   <= CW'(1);
      end
      gcm_pkg::S_EU_MUL: begin
        e_r0 <= e_r1;
        e_r1 <= rem[W-1:0];
        c0   <= c1;
        c1   <= ct;
      end
      gcm_pkg::S_TM: t <= rem[W-1:0];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == gcm_pkg::S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == gcm_pkg::S_DONE && (!m_tvalid || m_tready)) begin
      out_st  <= acc_st;
      out_res <= (acc_st == gcm_pkg::ST_OK) ? acc_res : '0;
      out_mod <= (acc_st == gcm_pkg::ST_OK) ? acc_mod : '0;
    end
  end

endmodule
